>>> src/rnm_pkg.sv
`timescale 1ns / 1ps

package rnm_pkg;

  // Pattern size limits
  localparam int unsigned MaxElements  = 8;
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned LengthWidth  = 4;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 64;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgPatternChars  = 3'd0,
    CfgAnyMask       = 3'd1,
    CfgStarMask      = 3'd2,
    CfgPlusMask      = 3'd3,
    CfgPatternLength = 3'd4,
    CfgAnchorStart   = 3'd5,
    CfgAnchorEnd     = 3'd6
  } cfg_reg_e;

  // Pattern configuration as seen by the NFA step logic
  typedef struct packed {
    logic [MaxElements*CharWidth-1:0] pattern_chars;
    logic [MaxElements-1:0]           any_mask;
    logic [MaxElements-1:0]           star_mask;
    logic [MaxElements-1:0]           plus_mask;
    logic [LengthWidth-1:0]           pattern_length;
    logic                             anchor_start;
    logic                             anchor_end;
  } cfg_t;

endpackage

>>> src/rnm_nfa_step.sv
`timescale 1ns / 1ps

// One text byte through the bit-parallel NFA: epsilon closure, byte step,
// second closure, and the found-flag update.
module rnm_nfa_step
  import rnm_pkg::*;
#(
  parameter int unsigned PatternElements = MaxElements
) (
  input  cfg_t                       cfg_i,
  input  logic [PatternElements:0]   pos_i,
  input  logic [PatternElements-1:0] rep_i,
  input  logic                       at_start_i,
  input  logic                       found_i,
  input  logic [CharWidth-1:0]       text_char_i,
  input  logic                       last_char_i,
  output logic [PatternElements:0]   pos_o,
  output logic [PatternElements-1:0] rep_o,
  output logic                       found_o
);

  localparam int unsigned N  = PatternElements;
  localparam int unsigned LW = $clog2(N + 1);

  logic [LW-1:0]  len;
  logic [N-1:0]   star;
  logic [N-1:0]   plus_eff;
  logic [N:0]     pos_seed;
  logic [N:0]     pos_cl;
  logic [N:0]     pos_step;
  logic [N:0]     pos_next_cl;
  logic [N:0]     pos_mask;
  logic [N-1:0]   rep_step;
  logic           empty_never;
  logic           found_pre;
  logic           found_post;

  // Skip over star elements and over entered plus repeats (ripple, N steps)
  function automatic logic [N:0] closure(input logic [N:0]   pos,
                                         input logic [N-1:0] rep,
                                         input logic [N-1:0] st,
                                         input logic [N-1:0] pl,
                                         input logic [LW-1:0] ln);
    logic [N:0] p;
    p = pos;
    for (int k = 0; k < N; k++) begin
      if ((k < int'(ln)) && ((p[k] && st[k]) || (rep[k] && pl[k]))) begin
        p[k+1] = 1'b1;
      end
    end
    return p;
  endfunction

  // Clamp the length to the element count
  assign len = (cfg_i.pattern_length > LengthWidth'(N)) ? LW'(N)
                                                        : LW'(cfg_i.pattern_length);
  assign star     = cfg_i.star_mask[N-1:0];
  assign plus_eff = cfg_i.plus_mask[N-1:0] & ~cfg_i.star_mask[N-1:0];

  assign empty_never = (len == '0) && !cfg_i.anchor_start;

  // Start position enters on every byte unless anchored
  assign pos_seed = pos_i | {{N{1'b0}}, (at_start_i || !cfg_i.anchor_start)};
  assign pos_cl   = closure(pos_seed, rep_i, star, plus_eff, len);

  assign found_pre = !cfg_i.anchor_end && !empty_never && pos_cl[len];

  // Byte step across all elements in parallel
  always_comb begin
    logic hit;
    pos_step = '0;
    rep_step = '0;
    hit      = 1'b0;
    for (int k = 0; k < N; k++) begin
      hit = cfg_i.any_mask[k] ||
            (cfg_i.pattern_chars[CharWidth*k +: CharWidth] == text_char_i);
      if ((k < int'(len)) && hit) begin
        if (star[k]) begin
          pos_step[k] = pos_step[k] | pos_cl[k];
        end else if (plus_eff[k]) begin
          rep_step[k] = pos_cl[k] || rep_i[k];
        end else begin
          pos_step[k+1] = pos_step[k+1] | pos_cl[k];
        end
      end
    end
  end

  // Positions 0..len are live
  always_comb begin
    for (int p = 0; p <= N; p++) begin
      pos_mask[p] = (p <= int'(len));
    end
  end

  assign pos_next_cl = closure(pos_step, rep_step, star, plus_eff, len) & pos_mask;

  assign found_post = !empty_never && pos_next_cl[len] &&
                      (!cfg_i.anchor_end || last_char_i);

  assign pos_o   = pos_next_cl;
  assign rep_o   = rep_step;
  assign found_o = found_i || found_pre || found_post;

endmodule

>>> src/regex_nfa_matcher_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       request    in_valid_i / in_stall_o   text_char_i, last_char_i
// out      result     out_valid_o / out_stall_i match_found_o
// cfg      write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle while the input is not stalled: the NFA state register closes its loop
// through one pass of the step logic, so a byte is accepted in every cycle without a stall.
// The result appears on the output register the cycle after the last byte.
// Input stalls only while a result sits in the output register and is stalled.
// Reset clears the pattern registers and the NFA state; no clearing pass.

module regex_nfa_matcher_core
  import rnm_pkg::*;
#(
  parameter int unsigned PatternElements = MaxElements
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // text input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CharWidth-1:0]    text_char_i,
  input  logic                    last_char_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    match_found_o,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int unsigned N = PatternElements;

  cfg_t           cfg_q;
  logic [N:0]     pos_q, pos_d;
  logic [N-1:0]   rep_q, rep_d;
  logic           found_q, found_d;
  logic           at_start_q;
  logic           out_valid_q;
  logic           match_q;
  logic           in_fire;
  logic           out_fire;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgPatternChars:  cfg_q.pattern_chars  <= cfg_data_i;
        CfgAnyMask:       cfg_q.any_mask       <= cfg_data_i[MaxElements-1:0];
        CfgStarMask:      cfg_q.star_mask      <= cfg_data_i[MaxElements-1:0];
        CfgPlusMask:      cfg_q.plus_mask      <= cfg_data_i[MaxElements-1:0];
        CfgPatternLength: cfg_q.pattern_length <= cfg_data_i[LengthWidth-1:0];
        CfgAnchorStart:   cfg_q.anchor_start   <= cfg_data_i[0];
        CfgAnchorEnd:     cfg_q.anchor_end     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  // NFA step
  rnm_nfa_step #(
    .PatternElements(N)
  ) u_step (
    .cfg_i      (cfg_q),
    .pos_i      (pos_q),
    .rep_i      (rep_q),
    .at_start_i (at_start_q),
    .found_i    (found_q),
    .text_char_i(text_char_i),
    .last_char_i(last_char_i),
    .pos_o      (pos_d),
    .rep_o      (rep_d),
    .found_o    (found_d)
  );

  // NFA state; string end returns it to the start condition
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      rep_q      <= '0;
      found_q    <= 1'b0;
      at_start_q <= 1'b1;
    end else if (in_fire) begin
      if (last_char_i) begin
        pos_q      <= '0;
        rep_q      <= '0;
        found_q    <= 1'b0;
        at_start_q <= 1'b1;
      end else begin
        pos_q      <= pos_d;
        rep_q      <= rep_d;
        found_q    <= found_d;
        at_start_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && last_char_i) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_char_i) begin
      match_q <= found_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_found_o = match_q;

endmodule

>>> src/rnm_checker.sv
`timescale 1ns / 1ps

module rnm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic last_char_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic match_found_o
);

  // A string end always produces a result next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_char_i) |=> out_valid_o)
    else $error("string end without result");

  // Bytes inside a string never create a result
  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !last_char_i && !out_valid_o) |=> !out_valid_o)
    else $error("result without string end");

  // Input only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with free output");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(match_found_o)))
    else $error("stalled result changed");

endmodule

bind regex_nfa_matcher_core rnm_checker u_rnm_checker (.*);
